[rtl/text_console_writer_macros.svh]
// Assertion helpers for the console writer.
// Both expect clk and rst in scope and are off while reset is high.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// A condition that holds at every clock edge.
`define TCW_ASSERT_HOLDS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("console writer check failed");

// A condition that implies another at the same clock edge.
`define TCW_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("console writer check failed");

`endif

[rtl/tcw_pkg.sv]
`timescale 1ns / 1ps

package tcw_pkg;

  // Screen geometry.
  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int SCROLL_CELLS  = CELL_COUNT - SCREEN_WIDTH;

  // Internal widths follow from the geometry.
  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);

  // Port field widths.
  localparam int CMD_W   = 1;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUT  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

  // Character codes with special handling.
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'd32;

  // Reset values.
  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd7;
  localparam logic [CELL_W-1:0]  CELL_RESET  = 16'h0720;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_t;

endpackage

[rtl/text_console_writer.sv]
`timescale 1ns / 1ps
`include "text_console_writer_macros.svh"
// A put goes from ST_IDLE to ST_DONE and its result is then registered at the output;
// a read inside the screen passes ST_READ first. A scroll moves the rows up in ST_SCROLL
// and clears the bottom row in ST_FILL through the single write port of the cell memory.
// Items go one at a time: none is taken until the last result is handed over, and a
// stalled result waits. Reset (rst, synchronous) clears the cursor, sets the color to 7,
// then a clearing pass writes blanks to every cell; no item is taken meanwhile.
module text_console_writer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            text_color_valid,
  output logic                            text_color_ready,
  input  logic [tcw_pkg::COLOR_W-1:0]     text_color,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tcw_pkg::CMD_W-1:0]       command,
  input  logic [tcw_pkg::CHAR_W-1:0]      character,
  input  logic [tcw_pkg::POS_W-1:0]       cell_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tcw_pkg::POS_W-1:0]       cursor_position,
  output logic [tcw_pkg::CELL_W-1:0]      cell_value,
  output logic                            scrolled
);
  import tcw_pkg::*;

  state_t             state, state_next;
  logic [ROW_W-1:0]   row, row_next;
  logic [COL_W-1:0]   col, col_next;
  logic [CNT_W-1:0]   sweep, sweep_next;
  logic               wr_pend, wr_pend_next;
  logic [ADDR_W-1:0]  wr_addr, wr_addr_next;
  logic [CELL_W-1:0]  res_value, res_value_next;
  logic               res_scroll, res_scroll_next;
  logic [COLOR_W-1:0] color;
  logic               out_load;

  logic [ADDR_W-1:0]  cur_addr;
  logic [CELL_W-1:0]  blank_cell;

  // Cell memory ports.
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [CELL_W-1:0]  rd_data;
  logic [CELL_W-1:0]  store [CELL_COUNT];

  // Color register, written whenever the host offers it.
  assign text_color_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color <= COLOR_RESET;
    end else if (text_color_valid && text_color_ready) begin
      color <= text_color;
    end
  end

  // Linear cursor address and the blank cell in the current color.
  assign cur_addr   = ADDR_W'(ADDR_W'(row) * ADDR_W'(SCREEN_WIDTH)) + ADDR_W'(col);
  assign blank_cell = {color, CHAR_SPACE};

  // Cell memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= store[mem_raddr];
    end
  end

  // State and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      row        <= '0;
      col        <= '0;
      sweep      <= '0;
      wr_pend    <= 1'b0;
    end else begin
      state      <= state_next;
      row        <= row_next;
      col        <= col_next;
      sweep      <= sweep_next;
      wr_pend    <= wr_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr    <= wr_addr_next;
    res_value  <= res_value_next;
    res_scroll <= res_scroll_next;
  end

  // Next state, cursor update and memory control.
  always_comb begin
    state_next      = state;
    row_next        = row;
    col_next        = col;
    sweep_next      = sweep;
    wr_pend_next    = 1'b0;
    wr_addr_next    = wr_addr;
    res_value_next  = res_value;
    res_scroll_next = res_scroll;
    mem_we          = 1'b0;
    mem_waddr       = cur_addr;
    mem_wdata       = blank_cell;
    mem_re          = 1'b0;
    mem_raddr       = ADDR_W'(cell_index);
    out_load        = 1'b0;
    in_stall        = 1'b1;

    case (state)
      ST_CLEAR: begin
        // Post-reset pass writes the reset blank into every cell.
        mem_we    = 1'b1;
        mem_waddr = sweep[ADDR_W-1:0];
        mem_wdata = CELL_RESET;
        if (sweep == CNT_W'(CELL_COUNT - 1)) begin
          sweep_next = '0;
          state_next = ST_IDLE;
        end else begin
          sweep_next = sweep + CNT_W'(1);
        end
      end

      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          res_value_next  = '0;
          res_scroll_next = 1'b0;
          state_next      = ST_DONE;
          if (command == CMD_READ) begin
            // Reads outside the screen return zero.
            if (32'(cell_index) < CELL_COUNT) begin
              mem_re     = 1'b1;
              state_next = ST_READ;
            end
          end else if (character == CHAR_BACKSPACE) begin
            // Backspace at the left edge leaves everything as it is.
            if (col != '0) begin
              col_next  = col - COL_W'(1);
              mem_we    = 1'b1;
              mem_waddr = cur_addr - ADDR_W'(1);
            end
          end else begin
            // Ordinary bytes are stored at the cursor first.
            if (character != CHAR_NEWLINE) begin
              mem_we    = 1'b1;
              mem_wdata = {color, character};
            end
            if (character == CHAR_NEWLINE || col == COL_W'(SCREEN_WIDTH - 1)) begin
              col_next = '0;
              if (row == ROW_W'(SCREEN_HEIGHT - 1)) begin
                res_scroll_next = 1'b1;
                sweep_next      = '0;
                state_next      = ST_SCROLL;
              end else begin
                row_next = row + ROW_W'(1);
              end
            end else begin
              col_next = col + COL_W'(1);
            end
          end
        end
      end

      ST_READ: begin
        res_value_next = rd_data;
        state_next     = ST_DONE;
      end

      ST_SCROLL: begin
        // Read one row ahead and write the data back in the next cycle.
        if (wr_pend) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr;
          mem_wdata = rd_data;
        end
        if (sweep == CNT_W'(SCROLL_CELLS)) begin
          state_next = ST_FILL;
        end else begin
          mem_re       = 1'b1;
          mem_raddr    = ADDR_W'(sweep + CNT_W'(SCREEN_WIDTH));
          wr_pend_next = 1'b1;
          wr_addr_next = sweep[ADDR_W-1:0];
          sweep_next   = sweep + CNT_W'(1);
        end
      end

      ST_FILL: begin
        // Bottom row is cleared with blanks in the current color.
        mem_we    = 1'b1;
        mem_waddr = sweep[ADDR_W-1:0];
        if (sweep == CNT_W'(CELL_COUNT - 1)) begin
          state_next = ST_DONE;
        end else begin
          sweep_next = sweep + CNT_W'(1);
        end
      end

      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cursor_position <= POS_W'(cur_addr);
      cell_value      <= res_value;
      scrolled        <= res_scroll;
    end
  end

  // The cursor always stays on the screen.
  `TCW_ASSERT_HOLDS(a_col_range, 32'(col) < SCREEN_WIDTH)
  `TCW_ASSERT_HOLDS(a_row_range, 32'(row) < SCREEN_HEIGHT)
  // After a scroll the cursor can only be on the last row.
  `TCW_ASSERT_IMPLIES(a_scroll_row, out_valid && scrolled, row == ROW_W'(SCREEN_HEIGHT - 1))
  // The fill only ever covers the bottom row.
  `TCW_ASSERT_IMPLIES(a_fill_range, state == ST_FILL, sweep >= CNT_W'(SCROLL_CELLS))

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  // One item as offered on the input channel.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  idx;
  } console_item_t;

  // One result as seen on the output channel.
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] value;
    logic              scrolled;
  } console_result_t;

  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  text_color_valid = 1'b0;
  logic                  text_color_ready;
  logic [COLOR_W-1:0]    text_color = COLOR_RESET;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      command = CMD_PUT;
  logic [CHAR_W-1:0]     character = '0;
  logic [POS_W-1:0]      cell_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [POS_W-1:0]      cursor_position;
  logic [CELL_W-1:0]     cell_value;
  logic                  scrolled;

  text_console_writer dut (
    .clk              (clk),
    .rst              (rst),
    .text_color_valid (text_color_valid),
    .text_color_ready (text_color_ready),
    .text_color       (text_color),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .character        (character),
    .cell_index       (cell_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .cursor_position  (cursor_position),
    .cell_value       (cell_value),
    .scrolled         (scrolled)
  );

  // Clock with a 10 ns period.
  always #5 clk = ~clk;

  // Shadow copy of the console: cursor, attribute and every cell.
  logic [CELL_W-1:0]  screen_cells [CELL_COUNT];
  int unsigned        cursor_row_now;
  int unsigned        cursor_col_now;
  logic [COLOR_W-1:0] attr_now;

  console_item_t   pending_items [$];
  console_result_t expected_results [$];
  console_item_t   on_bus;
  console_result_t predicted_now;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int accepted_items = 0;
  int hold_at = 32'h7fff_ffff;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int reads_seen = 0;
  int scrolls_seen = 0;
  int results_seen = 0;
  int mismatches = 0;

  // Moves the shadow cursor to the start of the next row, scrolling the
  // screen when it runs off the bottom. Returns 1 when a scroll happened.
  function automatic bit advance_line();
    cursor_col_now = 0;
    cursor_row_now++;
    if (cursor_row_now >= SCREEN_HEIGHT) begin
      for (int i = 0; i < SCROLL_CELLS; i++)
        screen_cells[i] = screen_cells[i + SCREEN_WIDTH];
      for (int i = SCROLL_CELLS; i < CELL_COUNT; i++)
        screen_cells[i] = {attr_now, CHAR_SPACE};
      cursor_row_now = SCREEN_HEIGHT - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one item to the shadow console and returns the result it causes.
  function automatic console_result_t predict_console(input console_item_t it);
    console_result_t r;
    r = '0;
    if (it.cmd == CMD_READ) begin
      if (it.idx < CELL_COUNT)
        r.value = screen_cells[it.idx];
    end else if (it.ch == CHAR_NEWLINE) begin
      r.scrolled = advance_line();
    end else if (it.ch == CHAR_BACKSPACE) begin
      // Backspace at column zero leaves everything as it is.
      if (cursor_col_now > 0) begin
        cursor_col_now--;
        screen_cells[cursor_row_now * SCREEN_WIDTH + cursor_col_now] = {attr_now, CHAR_SPACE};
      end
    end else begin
      screen_cells[cursor_row_now * SCREEN_WIDTH + cursor_col_now] = {attr_now, it.ch};
      cursor_col_now++;
      if (cursor_col_now >= SCREEN_WIDTH)
        r.scrolled = advance_line();
    end
    r.pos = POS_W'(cursor_row_now * SCREEN_WIDTH + cursor_col_now);
    return r;
  endfunction

  function automatic void queue_put(input logic [CHAR_W-1:0] ch);
    console_item_t it;
    it.cmd = CMD_PUT;
    it.ch  = ch;
    it.idx = POS_W'($urandom_range(2047));
    pending_items.push_back(it);
  endfunction

  function automatic void queue_read(input logic [POS_W-1:0] idx);
    console_item_t it;
    it.cmd = CMD_READ;
    it.ch  = CHAR_W'($urandom_range(255));
    it.idx = idx;
    pending_items.push_back(it);
  endfunction

  // Random traffic built from text runs, line feeds, backspace bursts and
  // reads, with a share of fully random items as noise.
  task automatic queue_traffic(input int count);
    int made;
    int run;
    int pick;
    console_item_t noise;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        run = ($urandom_range(9) == 0) ? $urandom_range(70, 100) : $urandom_range(1, 30);
        repeat (run) queue_put(CHAR_W'($urandom_range(255)));
        made += run;
        if ($urandom_range(99) < 60) begin
          queue_put(CHAR_NEWLINE);
          made++;
        end
      end else if (pick < 55) begin
        run = $urandom_range(1, 3);
        repeat (run) queue_put(CHAR_NEWLINE);
        made += run;
      end else if (pick < 68) begin
        run = $urandom_range(1, 6);
        repeat (run) queue_put(CHAR_BACKSPACE);
        made += run;
      end else if (pick < 90) begin
        run = $urandom_range(1, 4);
        repeat (run) begin
          if ($urandom_range(99) < 80)
            queue_read(POS_W'($urandom_range(CELL_COUNT - 1)));
          else
            queue_read(POS_W'($urandom_range(CELL_COUNT, 2047)));
        end
        made += run;
      end else begin
        noise.cmd = CMD_W'($urandom_range(1));
        noise.ch  = CHAR_W'($urandom_range(255));
        noise.idx = POS_W'($urandom_range(2047));
        pending_items.push_back(noise);
        made++;
      end
    end
  endtask

  // Waits until every queued item went in and every result came back.
  task automatic wait_for_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Writes the attribute register and updates the shadow copy on the handshake.
  task automatic load_attribute(input logic [COLOR_W-1:0] attr);
    @(posedge clk);
    text_color_valid <= 1'b1;
    text_color       <= attr;
    @(posedge clk);
    while (!text_color_ready) @(posedge clk);
    attr_now = attr;
    text_color_valid <= 1'b0;
  endtask

  // Driver: predicts each accepted item and offers the next pending one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_now = predict_console(on_bus);
        expected_results.push_back(predicted_now);
        accepted_items <= accepted_items + 1;
        if (on_bus.cmd == CMD_READ) reads_seen++;
        if (predicted_now.scrolled) scrolls_seen++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_items.pop_front();
          command    <= on_bus.cmd;
          character  <= on_bus.ch;
          cell_index <= on_bus.idx;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, armed once when the item count reaches hold_at.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_items >= hold_at) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    console_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected: pos=%0d cell=%h scroll=%0b",
                   $time, cursor_position, cell_value, scrolled);
        end else begin
          want = expected_results.pop_front();
          if (cursor_position !== want.pos || cell_value !== want.value ||
              scrolled !== want.scrolled) begin
            mismatches++;
            $display("%0t: result %0d want pos=%0d cell=%h scr=%0b got pos=%0d cell=%h scr=%0b",
                     $time, results_seen, want.pos, want.value, want.scrolled,
                     cursor_position, cell_value, scrolled);
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Stimulus and phase control.
  initial begin
    console_item_t odd;
    cursor_row_now = 0;
    cursor_col_now = 0;
    attr_now = COLOR_RESET;
    for (int i = 0; i < CELL_COUNT; i++) screen_cells[i] = CELL_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the reset attribute: reads at the edges of the
    // address range, backspace at column zero, extreme bytes, and a line feed.
    @(negedge clk);
    queue_read('0);
    queue_read(POS_W'(CELL_COUNT - 1));
    queue_read(POS_W'(CELL_COUNT));
    queue_read('1);
    queue_put(CHAR_BACKSPACE);
    queue_put(8'h41);
    queue_put(8'hFF);
    queue_put(8'h00);
    queue_put(8'h80);
    queue_put(CHAR_BACKSPACE);
    queue_read(POS_W'(3));
    queue_read(POS_W'(2));
    queue_put(CHAR_NEWLINE);
    queue_put(8'h7E);
    queue_read(POS_W'(SCREEN_WIDTH));
    odd.cmd = CMD_READ;
    odd.ch  = CHAR_NEWLINE;
    odd.idx = POS_W'(1);
    pending_items.push_back(odd);
    odd.cmd = CMD_PUT;
    odd.ch  = 8'h55;
    odd.idx = '1;
    pending_items.push_back(odd);
    queue_read(POS_W'(SCREEN_WIDTH + 1));
    wait_for_idle();

    // Random traffic with black-on-black attribute; sender idles less.
    load_attribute('0);
    @(negedge clk);
    send_idle_pct <= 27;
    recv_idle_pct <= 51;
    queue_traffic(450);
    wait_for_idle();

    // All-ones attribute; receiver idles less.
    load_attribute('1);
    @(negedge clk);
    send_idle_pct <= 51;
    recv_idle_pct <= 27;
    queue_traffic(450);
    wait_for_idle();

    // Random attribute, no idling, and one long receiver hold-off.
    load_attribute(COLOR_W'($urandom_range(1, 254)));
    @(negedge clk);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    hold_at = accepted_items + 30;
    queue_traffic(450);
    wait_for_idle();

    repeat (20) @(posedge clk);
    $display("Checked %0d results from %0d items: %0d reads, %0d screen scrolls.",
             results_seen, accepted_items, reads_seen, scrolls_seen);
    $display("Attribute set to reset, zero, all ones and a random value; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #200_000_000;
    $display("Timeout with %0d results still expected.", expected_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/tcw_pkg.sv
rtl/text_console_writer.sv
verif/tb_top.sv
